/* design/keyed_entry_table_defines.svh */
`ifndef KEYED_ENTRY_TABLE_DEFINES_SVH
`define KEYED_ENTRY_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clock, quiet during reset.
`define KET_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("keyed_entry_table: assertion failed");

// Next-cycle implication, sampled on clock, quiet during reset.
`define KET_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("keyed_entry_table: assertion failed");

`endif

/* design/ket_pkg.sv */
`default_nettype none

package ket_pkg;

   localparam int MAX_SLOTS = 16;
   localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W     = 5;
   localparam int CAP_W     = 5;
   localparam int HANDLE_W  = 16;
   localparam int KEY_W     = 8;

   localparam logic [1:0] ACT_INSERT      = 2'd0;
   localparam logic [1:0] ACT_REMOVE      = 2'd1;
   localparam logic [1:0] ACT_FIND_PLATE  = 2'd2;
   localparam logic [1:0] ACT_FIND_BRAND  = 2'd3;

   localparam logic [1:0] STS_DONE        = 2'd0;
   localparam logic [1:0] STS_NOT_FOUND   = 2'd1;
   localparam logic [1:0] STS_FULL        = 2'd2;
   localparam logic [1:0] STS_SEVERAL     = 2'd3;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [KEY_W-1:0]    brand;
      logic [KEY_W-1:0]    plate;
   } entry_type;

endpackage

`default_nettype wire

/* design/ket_if.sv */
`default_nettype none

interface ket_req_if import ket_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          action;
   logic [HANDLE_W-1:0] new_handle;
   logic [KEY_W-1:0]    new_brand_key;
   logic [KEY_W-1:0]    new_plate_key;
   logic [KEY_W-1:0]    search_key;

   modport source (output valid, action, new_handle, new_brand_key, new_plate_key,
                   search_key, input ready);
   modport sink   (input valid, action, new_handle, new_brand_key, new_plate_key,
                   search_key, output ready);
endinterface

interface ket_rsp_if import ket_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          status;
   logic [HANDLE_W-1:0] found_handle;
   logic [CNT_W-1:0]    count_after;

   modport source (output valid, status, found_handle, count_after, input ready);
   modport sink   (input valid, status, found_handle, count_after, output ready);
endinterface

interface ket_csr_if import ket_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* design/keyed_entry_table.sv */
// Channel    Dir  Beat payload
// ---------  ---  ----------------------------------------------------------
// req_bus    in   action, new_handle, new_brand_key, new_plate_key, search_key
// rsp_bus    out  status, found_handle, count_after
// csr_bus    in   capacity_in_use (always ready)
//
// Flow: an insert is written at accept, then passes through FIN to the rsp register.
// A search reads each held slot in turn through the registered read port; a
// plate hit ends it early. A remove that hits then shifts each later slot down.
// Reset: synchronous; clears count, sequencer, result valid; capacity = 16.
// Slot contents are not cleared: only reads of slots below the count are ever used.
// Stalls: req is ready only in IDLE; a result waits in FIN while rsp is held.
`default_nettype none

module keyed_entry_table import ket_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   ket_req_if.sink    req_bus,
   ket_rsp_if.source  rsp_bus,
   ket_csr_if.sink    csr_bus
);

`include "keyed_entry_table_defines.svh"

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_SHIFT = 2'd2;
   localparam logic [1:0] ST_FIN   = 2'd3;

   // sequencer and bookkeeping
   logic [1:0]          state_ff, state_in;
   logic [1:0]          op_ff, op_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [CNT_W-1:0]    held_count_ff, held_count_in;
   logic [CAP_W-1:0]    cap_ff;
   logic [CNT_W-1:0]    eff_cap;

   // scan pointer (can reach the count itself) and read pipeline tag
   logic [CNT_W-1:0]    ptr_ff, ptr_in;
   logic                pend_ff, pend_in;
   logic [IDX_W-1:0]    pend_idx_ff, pend_idx_in;
   logic                hit_ff, hit_in;

   // result being built, and the output register
   logic [1:0]          res_status_ff, res_status_in;
   logic [HANDLE_W-1:0] res_handle_ff, res_handle_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;

   // slot memory: one write port, one registered read port
   entry_type           mem [MAX_SLOTS];
   entry_type           rd_data_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   entry_type           wr_data;

   logic                req_acc;
   logic                issue;
   logic                rsp_free;
   logic                insert_ok;

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign req_acc              = req_bus.valid && req_bus.ready;
   assign csr_bus.ready        = 1'b1;
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.found_handle = rsp_handle_ff;
   assign rsp_bus.count_after  = rsp_count_ff;
   assign rsp_free             = !rsp_valid_ff || rsp_bus.ready;

   // capacity above the slot count acts as the slot count
   always_comb begin
      if (32'(cap_ff) > MAX_SLOTS) begin
         eff_cap = CNT_W'(MAX_SLOTS);
      end else begin
         eff_cap = CNT_W'(cap_ff);
      end
   end

   assign issue     = (ptr_ff < held_count_ff);
   assign rd_addr   = ptr_ff[IDX_W-1:0];
   assign insert_ok = req_acc && (req_bus.action == ACT_INSERT) && (held_count_ff < eff_cap);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      held_count_in = held_count_ff;
      ptr_in        = ptr_ff;
      pend_in       = 1'b0;
      pend_idx_in   = ptr_ff[IDX_W-1:0];
      hit_in        = hit_ff;
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = held_count_ff[IDX_W-1:0];
      wr_data       = '{handle: req_bus.new_handle, brand: req_bus.new_brand_key,
                        plate: req_bus.new_plate_key};

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               op_in         = req_bus.action;
               key_in        = req_bus.search_key;
               ptr_in        = '0;
               hit_in        = 1'b0;
               res_handle_in = '0;
               res_status_in = STS_NOT_FOUND;
               if (req_bus.action == ACT_INSERT) begin
                  // append at the tail, count stays below the slot count here
                  if (held_count_ff < eff_cap) begin
                     wr_en         = 1'b1;
                     held_count_in = held_count_ff + CNT_W'(1);
                     res_status_in = STS_DONE;
                  end else begin
                     res_status_in = STS_FULL;
                  end
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (issue) begin
               ptr_in  = ptr_ff + CNT_W'(1);
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               if (op_ff == ACT_FIND_BRAND) begin
                  // one hit keeps the handle, a second makes it ambiguous
                  if (rd_data_ff.brand == key_ff) begin
                     hit_in = 1'b1;
                     if (!hit_ff) begin
                        res_handle_in = rd_data_ff.handle;
                        res_status_in = STS_DONE;
                     end else begin
                        res_handle_in = '0;
                        res_status_in = STS_SEVERAL;
                     end
                  end
               end else if (rd_data_ff.plate == key_ff) begin
                  // first plate hit ends the scan
                  res_handle_in = rd_data_ff.handle;
                  res_status_in = STS_DONE;
                  pend_in       = 1'b0;
                  if (op_ff == ACT_REMOVE) begin
                     ptr_in   = CNT_W'(pend_idx_ff) + CNT_W'(1);
                     state_in = ST_SHIFT;
                  end else begin
                     state_in = ST_FIN;
                  end
               end
            end else if (!issue) begin
               state_in = ST_FIN;
            end
         end

         ST_SHIFT: begin
            // read slot j, write it to slot j-1 the next cycle
            if (issue) begin
               ptr_in  = ptr_ff + CNT_W'(1);
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_idx_ff - IDX_W'(1);
               wr_data = rd_data_ff;
            end else if (!issue) begin
               held_count_in = held_count_ff - CNT_W'(1);
               state_in      = ST_FIN;
            end
         end

         ST_FIN: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_handle_in = res_handle_ff;
               rsp_count_in  = held_count_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_count_ff <= '0;
         cap_ff        <= CAP_W'(MAX_SLOTS);
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_count_ff <= held_count_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_bus.valid && csr_bus.ready) begin
            cap_ff <= csr_bus.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      ptr_ff        <= ptr_in;
      pend_idx_ff   <= pend_idx_in;
      hit_ff        <= hit_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   `KET_ASSERT_NOW(a_count_bound, 1'b1, held_count_ff <= CNT_W'(MAX_SLOTS))
   `KET_ASSERT_NEXT(a_insert_grows, insert_ok, held_count_ff == $past(held_count_ff) + CNT_W'(1))
   `KET_ASSERT_NOW(a_miss_no_handle, rsp_valid_ff && rsp_status_ff != STS_DONE, rsp_handle_ff == '0)
   `KET_ASSERT_NOW(a_shift_nonempty, state_ff == ST_SHIFT, held_count_ff != '0)

endmodule

`default_nettype wire
